>>> sv/segment_intersection_point_macros.svh
// assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECTION_POINT_MACROS_SVH
`define SEGMENT_INTERSECTION_POINT_MACROS_SVH

// clocked assertion with active-low reset disable
`define SIP_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sip assertion failed");

// same, on the default clock and reset names
`define SIP_ASSERT_CK(name, prop) `SIP_ASSERT(name, clk_i, rst_ni, prop)

`endif

>>> sv/sip_pkg.sv
// package with shared types for the segment intersection block
`default_nettype none
package sip_pkg;

  typedef struct packed {
    logic hit;
    logic neg_x;
    logic neg_y;
  } sip_flags_t;

endpackage
`default_nettype wire

>>> sv/sip_if.sv
// handshake interfaces for segment pairs and crossing points
`default_nettype none
interface sip_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] a_start_lat;
  logic signed [W-1:0] a_start_lon;
  logic signed [W-1:0] a_end_lat;
  logic signed [W-1:0] a_end_lon;
  logic signed [W-1:0] b_start_lat;
  logic signed [W-1:0] b_start_lon;
  logic signed [W-1:0] b_end_lat;
  logic signed [W-1:0] b_end_lon;

  modport source (output valid, a_start_lat, a_start_lon, a_end_lat, a_end_lon,
                  b_start_lat, b_start_lon, b_end_lat, b_end_lon, input ready);
  modport sink (input valid, a_start_lat, a_start_lon, a_end_lat, a_end_lon,
                b_start_lat, b_start_lon, b_end_lat, b_end_lon, output ready);
endinterface

interface sip_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic                hit;
  logic signed [W-1:0] cross_lat;
  logic signed [W-1:0] cross_lon;

  modport source (output valid, hit, cross_lat, cross_lon, input ready);
  modport sink (input valid, hit, cross_lat, cross_lon, output ready);
endinterface
`default_nettype wire

>>> sv/segment_intersection_point.sv
// throughput: one transaction per cycle; the whole pipeline stalls together
// the quotient comes from a restoring divider with one pipeline stage per bit
// reset: asynchronous, active low, clears all stage valid bits
// top level of the segment intersection pipeline
`default_nettype none
module segment_intersection_point #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sip_in_if.sink    in_i,
  sip_out_if.source out_o
);
  import sip_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int D     = W + 1;
  localparam int PW    = 2 * D;
  localparam int OW    = 2 * D + 1;
  localparam int CW    = 2 * W + 1;
  localparam int NW    = 3 * W + 3;
  localparam int NSTG  = W + 7;

  logic            en;
  logic [NSTG-1:0] vld_q;

  // stage 1: coordinate differences
  logic signed [W-1:0] x_c [4];
  logic signed [W-1:0] y_c [4];
  logic signed [D-1:0] ma_d [10];
  logic signed [D-1:0] mb_d [10];
  logic signed [D-1:0] s1_ma_q [10];
  logic signed [D-1:0] s1_mb_q [10];
  logic signed [W-1:0] s1_x_q [4];
  logic signed [W-1:0] s1_y_q [4];

  // stage 2: products
  logic signed [PW-1:0]  s2_p_q [10];
  logic signed [2*W-1:0] s2_c_q [4];
  logic signed [D-1:0]   s2_dx12_q, s2_dy12_q, s2_dx34_q, s2_dy34_q;

  // stage 3: sums and crossing test
  logic signed [OW-1:0] o_d [4];
  logic [3:0]           neg_d, pos_d;
  logic                 s3_hit_q;
  logic signed [OW-1:0] s3_den_q;
  logic signed [CW-1:0] s3_c12_q, s3_c34_q;
  logic signed [D-1:0]  s3_dx12_q, s3_dy12_q, s3_dx34_q, s3_dy34_q;

  // stage 4: split numerator products
  logic signed [PW-1:0] s4_lo_q [4];
  logic signed [PW-1:0] s4_hi_q [4];
  logic                 s4_hit_q;
  logic signed [OW-1:0] s4_den_q;

  // stage 5: numerators
  logic signed [NW-1:0] s5_nx_q, s5_ny_q;
  logic                 s5_hit_q;
  logic signed [OW-1:0] s5_den_q;

  // divider stages, index 0 is the magnitude stage
  logic [NW-1:0] remx_q [W+1];
  logic [NW-1:0] remy_q [W+1];
  logic [W-1:0]  qx_q [W+1];
  logic [W-1:0]  qy_q [W+1];
  logic [OW-1:0] dm_q [W+1];
  sip_flags_t    flg_q [W+1];

  logic                out_hit_q;
  logic signed [W-1:0] out_lat_q, out_lon_q;

  function automatic logic signed [D-1:0] sub_ext(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    sub_ext = D'(a) - D'(b);
  endfunction

  assign en         = !vld_q[NSTG-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_i.valid};
    end
  end

  assign x_c[0] = in_i.a_start_lat;
  assign y_c[0] = in_i.a_start_lon;
  assign x_c[1] = in_i.a_end_lat;
  assign y_c[1] = in_i.a_end_lon;
  assign x_c[2] = in_i.b_start_lat;
  assign y_c[2] = in_i.b_start_lon;
  assign x_c[3] = in_i.b_end_lat;
  assign y_c[3] = in_i.b_end_lon;

  always_comb begin
    // orientation of b start and b end against segment a, and of a against b
    ma_d[0] = sub_ext(x_c[3], x_c[0]);  mb_d[0] = sub_ext(y_c[2], y_c[0]);
    ma_d[1] = sub_ext(x_c[2], x_c[0]);  mb_d[1] = sub_ext(y_c[3], y_c[0]);
    ma_d[2] = sub_ext(x_c[3], x_c[1]);  mb_d[2] = sub_ext(y_c[2], y_c[1]);
    ma_d[3] = sub_ext(x_c[2], x_c[1]);  mb_d[3] = sub_ext(y_c[3], y_c[1]);
    ma_d[4] = sub_ext(x_c[2], x_c[0]);  mb_d[4] = sub_ext(y_c[1], y_c[0]);
    ma_d[5] = sub_ext(x_c[1], x_c[0]);  mb_d[5] = sub_ext(y_c[2], y_c[0]);
    ma_d[6] = sub_ext(x_c[3], x_c[0]);  mb_d[6] = sub_ext(y_c[1], y_c[0]);
    ma_d[7] = sub_ext(x_c[1], x_c[0]);  mb_d[7] = sub_ext(y_c[3], y_c[0]);
    // denominator terms
    ma_d[8] = sub_ext(x_c[0], x_c[1]);  mb_d[8] = sub_ext(y_c[2], y_c[3]);
    ma_d[9] = sub_ext(y_c[0], y_c[1]);  mb_d[9] = sub_ext(x_c[2], x_c[3]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ma_q <= ma_d;
      s1_mb_q <= mb_d;
      s1_x_q  <= x_c;
      s1_y_q  <= y_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 10; i++) begin
        s2_p_q[i] <= PW'(s1_ma_q[i]) * PW'(s1_mb_q[i]);
      end
      s2_c_q[0] <= (2*W)'(s1_x_q[0]) * (2*W)'(s1_y_q[1]);
      s2_c_q[1] <= (2*W)'(s1_y_q[0]) * (2*W)'(s1_x_q[1]);
      s2_c_q[2] <= (2*W)'(s1_x_q[2]) * (2*W)'(s1_y_q[3]);
      s2_c_q[3] <= (2*W)'(s1_y_q[2]) * (2*W)'(s1_x_q[3]);
      s2_dx12_q <= s1_ma_q[8];
      s2_dy34_q <= s1_mb_q[8];
      s2_dy12_q <= s1_ma_q[9];
      s2_dx34_q <= s1_mb_q[9];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      o_d[i]   = OW'(s2_p_q[2*i]) - OW'(s2_p_q[2*i+1]);
      neg_d[i] = o_d[i][OW-1];
      pos_d[i] = !o_d[i][OW-1] && (o_d[i] != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_hit_q  <= ((neg_d[0] && pos_d[1]) || (pos_d[0] && neg_d[1])) &&
                   ((neg_d[2] && pos_d[3]) || (pos_d[2] && neg_d[3]));
      s3_den_q  <= OW'(s2_p_q[8]) - OW'(s2_p_q[9]);
      s3_c12_q  <= CW'(s2_c_q[0]) - CW'(s2_c_q[1]);
      s3_c34_q  <= CW'(s2_c_q[2]) - CW'(s2_c_q[3]);
      s3_dx12_q <= s2_dx12_q;
      s3_dy12_q <= s2_dy12_q;
      s3_dx34_q <= s2_dx34_q;
      s3_dy34_q <= s2_dy34_q;
    end
  end

  // low halves taken unsigned, high halves signed
  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_lo_q[0] <= PW'(signed'({1'b0, s3_c12_q[W-1:0]})) * PW'(s3_dx34_q);
      s4_hi_q[0] <= PW'(signed'(s3_c12_q[CW-1:W])) * PW'(s3_dx34_q);
      s4_lo_q[1] <= PW'(signed'({1'b0, s3_c34_q[W-1:0]})) * PW'(s3_dx12_q);
      s4_hi_q[1] <= PW'(signed'(s3_c34_q[CW-1:W])) * PW'(s3_dx12_q);
      s4_lo_q[2] <= PW'(signed'({1'b0, s3_c12_q[W-1:0]})) * PW'(s3_dy34_q);
      s4_hi_q[2] <= PW'(signed'(s3_c12_q[CW-1:W])) * PW'(s3_dy34_q);
      s4_lo_q[3] <= PW'(signed'({1'b0, s3_c34_q[W-1:0]})) * PW'(s3_dy12_q);
      s4_hi_q[3] <= PW'(signed'(s3_c34_q[CW-1:W])) * PW'(s3_dy12_q);
      s4_hit_q   <= s3_hit_q;
      s4_den_q   <= s3_den_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_nx_q  <= ((NW'(s4_hi_q[0]) <<< W) + NW'(s4_lo_q[0])) -
                  ((NW'(s4_hi_q[1]) <<< W) + NW'(s4_lo_q[1]));
      s5_ny_q  <= ((NW'(s4_hi_q[2]) <<< W) + NW'(s4_lo_q[2])) -
                  ((NW'(s4_hi_q[3]) <<< W) + NW'(s4_lo_q[3]));
      s5_hit_q <= s4_hit_q;
      s5_den_q <= s4_den_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      remx_q[0]       <= s5_nx_q[NW-1] ? NW'(-s5_nx_q) : NW'(s5_nx_q);
      remy_q[0]       <= s5_ny_q[NW-1] ? NW'(-s5_ny_q) : NW'(s5_ny_q);
      dm_q[0]         <= s5_den_q[OW-1] ? OW'(-s5_den_q) : OW'(s5_den_q);
      qx_q[0]         <= '0;
      qy_q[0]         <= '0;
      flg_q[0].hit    <= s5_hit_q;
      flg_q[0].neg_x  <= s5_nx_q[NW-1] ^ s5_den_q[OW-1];
      flg_q[0].neg_y  <= s5_ny_q[NW-1] ^ s5_den_q[OW-1];
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    localparam int B = W - 1 - k;
    logic [NW-1:0] sh;
    logic [NW:0]   tx, ty;

    assign sh = NW'(dm_q[k]) << B;
    assign tx = {1'b0, remx_q[k]} - {1'b0, sh};
    assign ty = {1'b0, remy_q[k]} - {1'b0, sh};

    always_ff @(posedge clk_i) begin
      if (en) begin
        remx_q[k+1] <= tx[NW] ? remx_q[k] : tx[NW-1:0];
        remy_q[k+1] <= ty[NW] ? remy_q[k] : ty[NW-1:0];
        qx_q[k+1]   <= qx_q[k] | (W'(!tx[NW]) << B);
        qy_q[k+1]   <= qy_q[k] | (W'(!ty[NW]) << B);
        dm_q[k+1]   <= dm_q[k];
        flg_q[k+1]  <= flg_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q <= flg_q[W].hit;
      if (flg_q[W].hit) begin
        out_lat_q <= flg_q[W].neg_x ? -signed'(qx_q[W]) : signed'(qx_q[W]);
        out_lon_q <= flg_q[W].neg_y ? -signed'(qy_q[W]) : signed'(qy_q[W]);
      end else begin
        out_lat_q <= '0;
        out_lon_q <= '0;
      end
    end
  end

  assign out_o.valid     = vld_q[NSTG-1];
  assign out_o.hit       = out_hit_q;
  assign out_o.cross_lat = out_lat_q;
  assign out_o.cross_lon = out_lon_q;

endmodule
`default_nettype wire

>>> sv/sip_checker.sv
// port-level checker for the segment intersection block, with its bind
`default_nettype none
`include "segment_intersection_point_macros.svh"
module sip_checker #(
  parameter int COORD_WIDTH = 32
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_ready_i,
  input wire logic                   out_valid_i,
  input wire logic                   out_ready_i,
  input wire logic                   out_hit_i,
  input wire logic [COORD_WIDTH-1:0] out_lat_i,
  input wire logic [COORD_WIDTH-1:0] out_lon_i
);

  `SIP_ASSERT_CK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_hit_i) && $stable(out_lat_i) && $stable(out_lon_i))
  `SIP_ASSERT_CK(a_miss_zero, out_valid_i && !out_hit_i |-> out_lat_i == '0 && out_lon_i == '0)
  `SIP_ASSERT_CK(a_ready_when_empty, !out_valid_i |-> in_ready_i)
  `SIP_ASSERT_CK(a_ready_when_taken, out_valid_i && out_ready_i |-> in_ready_i)

endmodule

bind segment_intersection_point sip_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sip_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_hit_i   (out_o.hit),
  .out_lat_i   (out_o.cross_lat),
  .out_lon_i   (out_o.cross_lon)
);
`default_nettype wire

>>> tb/tb.sv
// testbench for the segment intersection pipeline: directed table, then random pairs
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 32;
  localparam int LATENCY = W + 7;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 450;

  typedef logic signed [W-1:0] coord_t;
  typedef logic signed [191:0] acc_t;

  typedef struct {
    coord_t c[8];
  } seg_pair_t;

  typedef struct {
    logic   hit;
    coord_t lat;
    coord_t lon;
  } crossing_t;

  typedef struct {
    seg_pair_t pair;
    logic      has_expect;
    crossing_t expect_pt;
  } table_row_t;

  logic clk_i;
  logic rst_ni;

  sip_in_if  #(.W(W)) pair_if ();
  sip_out_if #(.W(W)) point_if ();

  segment_intersection_point #(.COORD_WIDTH(W)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pair_if),
    .out_o (point_if)
  );

  crossing_t  pending_points[$];
  table_row_t directed_rows[$];
  int errors;
  int n_sent;
  int n_recv;
  int n_hits;
  int idle_cycles;
  bit long_hold;
  bit stim_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int orient_sign(acc_t px, acc_t py, acc_t qx, acc_t qy,
                                     acc_t rx, acc_t ry);
    acc_t d;
    d = (rx - px) * (qy - py) - (qx - px) * (ry - py);
    return (d < 0) ? -1 : ((d == 0) ? 0 : 1);
  endfunction

  function automatic crossing_t crossing_of(seg_pair_t s);
    crossing_t r;
    acc_t x1, y1, x2, y2, x3, y3, x4, y4;
    acc_t den, c12, c34, nx, ny;
    int o1, o2, o3, o4;
    x1 = s.c[0]; y1 = s.c[1]; x2 = s.c[2]; y2 = s.c[3];
    x3 = s.c[4]; y3 = s.c[5]; x4 = s.c[6]; y4 = s.c[7];
    r = '{hit: 1'b0, lat: '0, lon: '0};
    o1 = orient_sign(x1, y1, x3, y3, x4, y4);
    o2 = orient_sign(x2, y2, x3, y3, x4, y4);
    o3 = orient_sign(x1, y1, x2, y2, x3, y3);
    o4 = orient_sign(x1, y1, x2, y2, x4, y4);
    if (!(o1 * o2 < 0 && o3 * o4 < 0)) return r;
    den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
    if (den == 0) return r;
    c12 = x1 * y2 - y1 * x2;
    c34 = x3 * y4 - y3 * x4;
    nx = c12 * (x3 - x4) - (x1 - x2) * c34;
    ny = c12 * (y3 - y4) - (y1 - y2) * c34;
    r.hit = 1'b1;
    r.lat = coord_t'(nx / den);
    r.lon = coord_t'(ny / den);
    return r;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(2000) - 1000);
      default: return coord_t'(($urandom_range(2000) - 1000) * 4096);
    endcase
  endfunction

  function automatic seg_pair_t make_pair(coord_t v0, coord_t v1, coord_t v2, coord_t v3,
                                          coord_t v4, coord_t v5, coord_t v6, coord_t v7);
    seg_pair_t s;
    s.c[0] = v0; s.c[1] = v1; s.c[2] = v2; s.c[3] = v3;
    s.c[4] = v4; s.c[5] = v5; s.c[6] = v6; s.c[7] = v7;
    return s;
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t s;
    int mode;
    mode = $urandom_range(2);
    for (int i = 0; i < 8; i++) s.c[i] = rand_coord(mode);
    if ($urandom_range(3) != 0) begin
      // build b across a so most pairs really cross
      s.c[4] = s.c[0] + (s.c[2] - s.c[0]) / 2 + rand_coord(1);
      s.c[5] = s.c[1] + (s.c[3] - s.c[1]) / 2 + rand_coord(1);
      s.c[6] = s.c[4] - (s.c[5] - s.c[1]) / 2;
      s.c[7] = s.c[5] + (s.c[4] - s.c[0]) / 2;
      s.c[4] = s.c[4] + (s.c[5] - s.c[1]) / 2;
      s.c[5] = s.c[5] - (s.c[4] - s.c[0]) / 4;
    end else if ($urandom_range(3) == 0) begin
      // collinear or shared endpoint
      s.c[4] = s.c[2];
      s.c[5] = s.c[3];
    end
    return s;
  endfunction

  task automatic send_pair(seg_pair_t s);
    pair_if.valid       <= 1'b1;
    pair_if.a_start_lat <= s.c[0];
    pair_if.a_start_lon <= s.c[1];
    pair_if.a_end_lat   <= s.c[2];
    pair_if.a_end_lon   <= s.c[3];
    pair_if.b_start_lat <= s.c[4];
    pair_if.b_start_lon <= s.c[5];
    pair_if.b_end_lat   <= s.c[6];
    pair_if.b_end_lon   <= s.c[7];
    do @(posedge clk_i); while (!pair_if.ready);
    pending_points.push_back(crossing_of(s));
    n_sent++;
  endtask

  task automatic gap_sender();
    int g;
    g = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(2);
    if (n_sent > 200 && n_sent < 260) g = 0;
    if (g > 0) begin
      pair_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic void add_row(seg_pair_t s, logic known, crossing_t e);
    table_row_t r;
    r.pair = s;
    r.has_expect = known;
    r.expect_pt = e;
    directed_rows.push_back(r);
  endfunction

  initial begin
    coord_t mx, mn;
    crossing_t none, origin;
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    none = '{hit: 1'b0, lat: '0, lon: '0};
    origin = '{hit: 1'b1, lat: '0, lon: '0};
    errors = 0; n_sent = 0; n_recv = 0; n_hits = 0; stim_done = 0;
    rst_ni = 1'b0;
    pair_if.valid <= 1'b0;
    pair_if.a_start_lat <= '0; pair_if.a_start_lon <= '0;
    pair_if.a_end_lat <= '0; pair_if.a_end_lon <= '0;
    pair_if.b_start_lat <= '0; pair_if.b_start_lon <= '0;
    pair_if.b_end_lat <= '0; pair_if.b_end_lon <= '0;

    add_row(make_pair(-10, 0, 10, 0, 0, -10, 0, 10), 1'b1, origin);
    add_row(make_pair(mn, mn, mx, mx, mn, mx, mx, mn), 1'b0, none);
    add_row(make_pair(mn, 0, mx, 0, 0, mn, 0, mx), 1'b0, none);
    add_row(make_pair(0, 0, 10, 10, 20, 20, 30, 30), 1'b1, none);
    add_row(make_pair(0, 0, 10, 10, 5, 5, 30, 30), 1'b1, none);
    add_row(make_pair(0, 0, 10, 0, 10, 0, 10, 10), 1'b1, none);
    add_row(make_pair(0, 0, 10, 0, 5, 0, 5, 10), 1'b1, none);
    add_row(make_pair(0, 0, 10, 0, 0, 5, 10, 5), 1'b1, none);
    add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none);
    add_row(make_pair(mx, mx, mx, mx, mx, mx, mx, mx), 1'b1, none);
    add_row(make_pair(mn, mn, mn, mn, mn, mn, mn, mn), 1'b1, none);
    add_row(make_pair(-1, -1, 1, 1, -1, 1, 1, -1), 1'b1, origin);
    add_row(make_pair(0, 0, 3, 1, 0, 1, 3, 0), 1'b0, none);
    add_row(make_pair(-7, -3, 5, 9, 6, -8, -4, 4), 1'b0, none);
    add_row(make_pair(mx, mn, mn, mx, mx, mx, mn, mn), 1'b0, none);
    add_row(make_pair(mn, mn, mx, mx, mn + 1, mx, mx - 1, mn), 1'b0, none);
    add_row(make_pair(-1, mx, -1, mn, mn, -1, mx, -1), 1'b0, none);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_pair(directed_rows[i].pair);
      if (directed_rows[i].has_expect && crossing_of(directed_rows[i].pair) !=
          directed_rows[i].expect_pt) begin
        $display("%0t predictor disagrees with table row %0d", $time, i);
        errors++;
      end
      gap_sender();
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        // drain completely before continuing
        pair_if.valid <= 1'b0;
        wait (pending_points.size() == 0);
        @(posedge clk_i);
      end
      send_pair(random_pair());
      gap_sender();
    end
    pair_if.valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    int hold;
    long_hold = 0;
    point_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold && n_sent > 210) begin
        long_hold = 1;
        point_if.ready <= 1'b0;
        repeat (3 * LATENCY) @(posedge clk_i);
      end
      hold = ($urandom_range(9) == 0) ? $urandom_range(25, 6) : $urandom_range(1);
      if (n_sent > 350 && n_sent < 400) hold = 0;
      point_if.ready <= (hold == 0);
      if (hold > 1) repeat (hold - 1) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    crossing_t e;
    if (rst_ni && point_if.valid && point_if.ready) begin
      n_recv++;
      if (pending_points.size() == 0) begin
        $display("%0t unexpected result hit=%0b lat=%0d lon=%0d", $time,
                 point_if.hit, point_if.cross_lat, point_if.cross_lon);
        errors++;
      end else begin
        e = pending_points.pop_front();
        if (e.hit) n_hits++;
        if (point_if.hit !== e.hit) begin
          $display("%0t hit expected %0b actual %0b", $time, e.hit, point_if.hit);
          errors++;
        end
        if (point_if.cross_lat !== e.lat) begin
          $display("%0t cross_lat expected %0d actual %0d", $time, e.lat,
                   point_if.cross_lat);
          errors++;
        end
        if (point_if.cross_lon !== e.lon) begin
          $display("%0t cross_lon expected %0d actual %0d", $time, e.lon,
                   point_if.cross_lon);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (pair_if.valid && pair_if.ready) ||
        (point_if.valid && point_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    idle_cycles = 0;
    wait (stim_done);
    wait (pending_points.size() == 0 || idle_cycles >= WATCHDOG);
    if (idle_cycles < WATCHDOG) repeat (2 * LATENCY) @(posedge clk_i);
    if (idle_cycles >= WATCHDOG || pending_points.size() != 0) begin
      $display("%0t timeout, %0d results missing", $time, pending_points.size());
      $display("segment_intersection_point test failed");
      $finish;
    end else begin
      $display("sent %0d segment pairs, received %0d points, %0d crossings", n_sent,
               n_recv, n_hits);
      if (errors == 0) begin
        $display("segment_intersection_point test passed");
      end else begin
        $display("segment_intersection_point test failed");
      end
      $finish;
    end
  end

  initial begin
    wait (rst_ni);
    wait (idle_cycles >= WATCHDOG);
    $display("%0t timeout, no transaction for %0d cycles", $time, WATCHDOG);
    $display("segment_intersection_point test failed");
    $finish;
  end
endmodule
`default_nettype wire

>>> segment_intersection_point.f
+incdir+sv
sv/sip_pkg.sv
sv/sip_if.sv
sv/segment_intersection_point.sv
sv/sip_checker.sv
tb/tb.sv
